// File: hdl/mbds_pkg.sv
// Package for the Margolus block density settle core: cell packing constants,
// item types and the settle functions. No dependencies.
package mbds_pkg;

    localparam int DENSITY_BITS     = 8;
    localparam int MATERIAL_ID_BITS = 6;
    localparam int CELL_BITS        = 16;
    localparam int BLOCK_CELLS      = 8;
    localparam int LAT_VISITS       = 4;
    localparam int LIQ_BIT          = MATERIAL_ID_BITS;
    localparam int MOV_BIT          = MATERIAL_ID_BITS + 1;
    localparam int RANK_SHIFT       = MATERIAL_ID_BITS + 2;

    typedef logic [CELL_BITS-1:0]    cell_t;
    typedef logic [DENSITY_BITS-1:0] rank_t;
    typedef cell_t [BLOCK_CELLS-1:0] blk_t;

    typedef struct packed {
        cell_t cell_7;
        cell_t cell_6;
        cell_t cell_5;
        cell_t cell_4;
        cell_t cell_3;
        cell_t cell_2;
        cell_t cell_1;
        cell_t cell_0;
    } src_item_t;

    typedef struct packed {
        cell_t                  out_7;
        cell_t                  out_6;
        cell_t                  out_5;
        cell_t                  out_4;
        cell_t                  out_3;
        cell_t                  out_2;
        cell_t                  out_1;
        cell_t                  out_0;
        logic [BLOCK_CELLS-1:0] changed_mask;
    } dst_item_t;

    // Rank bits beyond the cell word read as zero.
    function automatic rank_t cell_rank(input cell_t w);
        logic [CELL_BITS+DENSITY_BITS-1:0] ext;
        ext = {{DENSITY_BITS{1'b0}}, w};
        return ext[RANK_SHIFT +: DENSITY_BITS];
    endfunction

    function automatic logic may_displace(input cell_t a, input cell_t b);
        return a[MOV_BIT] && b[MOV_BIT] && (cell_rank(a) > cell_rank(b));
    endfunction

    // Vertical pass: the four columns are independent.
    function automatic blk_t vert_pass(input blk_t c);
        blk_t r;
        r = c;
        for (int col = 0; col < 4; col++) begin
            logic [2:0] lo;
            logic [2:0] up;
            lo = {col[1], 1'b0, col[0]};
            up = {col[1], 1'b1, col[0]};
            if (may_displace(c[up], c[lo]))
            begin
                r[up] = c[lo];
                r[lo] = c[up];
            end
        end
        return r;
    endfunction

    // One lateral visit of the upper cell at column (lx, lz).
    function automatic blk_t lat_visit(input blk_t c, input logic lx, input logic lz);
        blk_t       r;
        cell_t      w;
        logic [2:0] up;
        logic [2:0] dxl;
        logic [2:0] dzl;
        logic [2:0] sxu;
        logic [2:0] szu;
        logic [2:0] tgt;
        logic       mv;
        r   = c;
        up  = {lz, 1'b1, lx};
        dxl = {lz, 1'b0, ~lx};
        dzl = {~lz, 1'b0, lx};
        sxu = {lz, 1'b1, ~lx};
        szu = {~lz, 1'b1, lx};
        w   = c[up];
        tgt = up;
        mv  = 1'b0;
        if (w[MOV_BIT])
        begin
            if (may_displace(w, c[dxl]))
            begin
                tgt = dxl;
                mv  = 1'b1;
            end
            else if (may_displace(w, c[dzl]))
            begin
                tgt = dzl;
                mv  = 1'b1;
            end
            else if (w[LIQ_BIT])
            begin
                if (may_displace(w, c[sxu]) && may_displace(w, c[dxl]))
                begin
                    tgt = sxu;
                    mv  = 1'b1;
                end
                else if (may_displace(w, c[szu]) && may_displace(w, c[dzl]))
                begin
                    tgt = szu;
                    mv  = 1'b1;
                end
            end
        end
        if (mv)
        begin
            r[up]  = c[tgt];
            r[tgt] = w;
        end
        return r;
    endfunction

endpackage

// File: hdl/margolus_block_density_settle_core.sv
// Margolus block density settle core: six-register pipeline that settles one
// 2x2x2 block per cycle while src_stall is low. Depends on mbds_pkg.
//
// Use:
//  - src carries one item: the eight cell words of a block, local index
//    x + 2y + 4z with y = 0 the lower layer. It is taken at a rising edge with
//    src_valid high and src_stall low.
//  - dst carries the settled cells and a mask of positions whose word changed.
//    The receiver holds dst_stall high to keep the item on the port.
//  - Stage 0 runs the vertical pass, stages 1 to 4 each run one lateral visit
//    (upper cells in x-then-z order), and the output register forms the mask.
//  - An accepted item passes through stage 0, stages 1 to 4 and the output
//    register before dst_valid rises; one item enters every cycle while
//    src_stall is low, set by the single pipeline with a register per pass.
//  - When dst stalls, items close up into empty stages; src_stall rises only
//    once stage 0 holds an item that cannot move on.
//  - Reset clears every valid bit, so the pipeline comes up empty; there is
//    no other state.
module margolus_block_density_settle_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  mbds_pkg::src_item_t src,
    output logic              dst_valid,
    input  logic              dst_stall,
    output mbds_pkg::dst_item_t dst
);
    import mbds_pkg::*;

    localparam int STAGES = LAT_VISITS + 1;

    // Pipeline stages: current arrangement and the original words for the mask.
    logic [STAGES-1:0] v_reg;
    blk_t              cur_reg  [STAGES];
    blk_t              org_reg  [STAGES];
    blk_t              cur_next [STAGES];
    blk_t              src_blk;
    logic [STAGES:0]   adv;
    logic              dst_valid_reg;
    dst_item_t         dst_reg;
    dst_item_t         dst_next;

    // Unpack the incoming item into an indexed block.
    assign src_blk[0] = src.cell_0;
    assign src_blk[1] = src.cell_1;
    assign src_blk[2] = src.cell_2;
    assign src_blk[3] = src.cell_3;
    assign src_blk[4] = src.cell_4;
    assign src_blk[5] = src.cell_5;
    assign src_blk[6] = src.cell_6;
    assign src_blk[7] = src.cell_7;

    // A stage may load when it is empty or its item moves on this cycle.
    always_comb
    begin
        adv[STAGES] = !dst_valid_reg || !dst_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign src_stall = !adv[0];

    // Stage logic: vertical pass first, then one lateral visit per stage.
    always_comb
    begin
        cur_next[0] = vert_pass(src_blk);
        for (int k = 1; k < STAGES; k++)
        begin
            logic [1:0] vis;
            vis = 2'(k - 1);
            cur_next[k] = lat_visit(cur_reg[k-1], vis[0], vis[1]);
        end
    end

    // Mark every position whose word differs from the one that came in.
    always_comb
    begin
        logic [BLOCK_CELLS-1:0] mask;
        for (int i = 0; i < BLOCK_CELLS; i++)
        begin
            mask[i] = (cur_reg[STAGES-1][i] != org_reg[STAGES-1][i]);
        end
        dst_next.out_0        = cur_reg[STAGES-1][0];
        dst_next.out_1        = cur_reg[STAGES-1][1];
        dst_next.out_2        = cur_reg[STAGES-1][2];
        dst_next.out_3        = cur_reg[STAGES-1][3];
        dst_next.out_4        = cur_reg[STAGES-1][4];
        dst_next.out_5        = cur_reg[STAGES-1][5];
        dst_next.out_6        = cur_reg[STAGES-1][6];
        dst_next.out_7        = cur_reg[STAGES-1][7];
        dst_next.changed_mask = mask;
    end

    // Valid bits travel with the data; a stalled stage holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= src_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (adv[STAGES])
            begin
                dst_valid_reg <= v_reg[STAGES-1];
            end
        end
    end

    // Payload registers: load when the stage advances, no reset.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cur_reg[0] <= cur_next[0];
            org_reg[0] <= src_blk;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                cur_reg[k] <= cur_next[k];
                org_reg[k] <= org_reg[k-1];
            end
        end
        if (adv[STAGES])
        begin
            dst_reg <= dst_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst       = dst_reg;

    // The input side stalls only while the first stage holds an item.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> v_reg[0])
        else $error("src_stall raised with stage 0 empty");

    // An item in the last stage always fills an empty output register.
    a_last_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STAGES-1] && !dst_valid_reg) |=> dst_valid_reg)
        else $error("item in last stage did not reach the output");

    // A delivered item with nothing behind it leaves the output empty.
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid_reg && !dst_stall && !v_reg[STAGES-1]) |=> !dst_valid_reg)
        else $error("output item repeated");

    // The result is a permutation, so exactly one changed position is impossible.
    a_mask_perm: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid_reg |-> ($countones(dst_reg.changed_mask) != 1))
        else $error("single changed position in a permuted block");

endmodule

// File: tb/sv/mbds_settle_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Margolus block density settle core: watches both item
// channels, settles each accepted block itself and compares the results.
// Depends on mbds_pkg for the item types and cell packing constants.
module mbds_settle_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  mbds_pkg::src_item_t src,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  mbds_pkg::dst_item_t dst,
    output int                  errors,
    output int                  pending,
    output int                  blocks_seen,
    output int                  moved_results
);
    import mbds_pkg::*;

    dst_item_t settled_q[$];

    initial
    begin
        errors        = 0;
        pending       = 0;
        blocks_seen   = 0;
        moved_results = 0;
    end

    function automatic logic [DENSITY_BITS-1:0] rank_of(input cell_t w);
        logic [31:0] wide;
        wide = 32'(w) >> RANK_SHIFT;
        return wide[DENSITY_BITS-1:0];
    endfunction

    function automatic logic outranks(input cell_t a, input cell_t b);
        return a[MOV_BIT] && b[MOV_BIT] && (rank_of(a) > rank_of(b));
    endfunction

    function automatic dst_item_t settle_block(input src_item_t b);
        cell_t     orig [8];
        cell_t     c [8];
        cell_t     w;
        dst_item_t r;
        int        lo;
        int        up;
        int        dxl;
        int        dzl;
        int        tgt;
        orig = '{b.cell_0, b.cell_1, b.cell_2, b.cell_3,
                 b.cell_4, b.cell_5, b.cell_6, b.cell_7};
        c = orig;
        // Sink the heavier upper cell of each column.
        for (int lz = 0; lz < 2; lz++)
            for (int lx = 0; lx < 2; lx++)
            begin
                lo = lx + 4 * lz;
                if (outranks(c[lo + 2], c[lo]))
                begin
                    w         = c[lo + 2];
                    c[lo + 2] = c[lo];
                    c[lo]     = w;
                end
            end
        // Spread upper cells sideways, one move each at most.
        for (int lz = 0; lz < 2; lz++)
            for (int lx = 0; lx < 2; lx++)
            begin
                up  = lx + 2 + 4 * lz;
                dxl = (1 - lx) + 4 * lz;
                dzl = lx + 4 * (1 - lz);
                w   = c[up];
                tgt = -1;
                if (w[MOV_BIT])
                begin
                    if (outranks(w, c[dxl]))
                        tgt = dxl;
                    else if (outranks(w, c[dzl]))
                        tgt = dzl;
                    else if (w[LIQ_BIT])
                    begin
                        if (outranks(w, c[dxl + 2]) && outranks(w, c[dxl]))
                            tgt = dxl + 2;
                        else if (outranks(w, c[dzl + 2]) && outranks(w, c[dzl]))
                            tgt = dzl + 2;
                    end
                end
                if (tgt >= 0)
                begin
                    c[up]  = c[tgt];
                    c[tgt] = w;
                end
            end
        r.out_0 = c[0];
        r.out_1 = c[1];
        r.out_2 = c[2];
        r.out_3 = c[3];
        r.out_4 = c[4];
        r.out_5 = c[5];
        r.out_6 = c[6];
        r.out_7 = c[7];
        for (int i = 0; i < BLOCK_CELLS; i++)
            r.changed_mask[i] = (c[i] != orig[i]);
        return r;
    endfunction

    task automatic report_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic compare_result(input dst_item_t got, input dst_item_t want);
        cell_t got_c [8];
        cell_t want_c [8];
        got_c  = '{got.out_0, got.out_1, got.out_2, got.out_3,
                   got.out_4, got.out_5, got.out_6, got.out_7};
        want_c = '{want.out_0, want.out_1, want.out_2, want.out_3,
                   want.out_4, want.out_5, want.out_6, want.out_7};
        for (int i = 0; i < BLOCK_CELLS; i++)
            if (got_c[i] !== want_c[i])
                report_error($sformatf("out_%0d is %h, expected %h", i, got_c[i], want_c[i]));
        if (got.changed_mask !== want.changed_mask)
            report_error($sformatf("changed_mask is %b, expected %b",
                                   got.changed_mask, want.changed_mask));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                settled_q = {settled_q, settle_block(src)};
                blocks_seen++;
            end
            if (dst_valid && !dst_stall)
            begin
                if (settled_q.size() == 0)
                    report_error("result item with no block outstanding");
                else
                begin
                    if (settled_q[0].changed_mask != '0)
                        moved_results++;
                    compare_result(dst, settled_q.pop_front());
                end
            end
            pending <= settled_q.size();
        end
    end

endmodule

// File: tb/sv/tb_margolus_block_density_settle_core.sv
`timescale 1ns / 100ps
// Top level of the density settle testbench: clock, reset, block stimulus and
// output back-pressure. Depends on mbds_pkg, the core and mbds_settle_checker.
module tb_margolus_block_density_settle_core;
    import mbds_pkg::*;

    localparam int          HOLDOFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_item_t src_item  = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    dst_item_t dst_item;

    int          errors;
    int          pending;
    int          blocks_seen;
    int          moved_results;
    int unsigned cycles       = 0;
    int          src_idle_pct = 0;
    int          dst_stall_pct = 0;
    logic        hold_req     = 1'b0;
    logic        hold_taken   = 1'b0;
    int          hold_left    = 0;

    margolus_block_density_settle_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst       (dst_item)
    );

    mbds_settle_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src           (src_item),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall),
        .dst           (dst_item),
        .errors        (errors),
        .pending       (pending),
        .blocks_seen   (blocks_seen),
        .moved_results (moved_results)
    );

    always #2 clk = ~clk;

    // Watchdog: stop a hung run well past the slowest legal finish.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("margolus_block_density_settle_core test failed");
            $finish;
        end
    end

    // Receiver: stall at the phase's rate, or hold off for one long stretch
    // on request so that the pipeline fills and pushes back on the sender.
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLDOFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            dst_stall <= 1'b1;
        end
        else
            dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    // Build one cell word from its fields at the package's packing.
    function automatic cell_t cell_word(input int rank, input logic mov, input logic liq,
                                        input int id);
        return (cell_t'(rank) << RANK_SHIFT) | (cell_t'(mov) << MOV_BIT)
             | (cell_t'(liq) << LIQ_BIT) | cell_t'(id[MATERIAL_ID_BITS-1:0]);
    endfunction

    function automatic cell_t solid(input int rank);
        return cell_word(rank, 1'b1, 1'b0, rank % 64);
    endfunction

    function automatic cell_t liquid(input int rank);
        return cell_word(rank, 1'b1, 1'b1, 63 - rank % 64);
    endfunction

    // Out-of-grid stand-in: immovable, whatever its rank.
    function automatic cell_t wall(input int rank);
        return cell_word(rank, 1'b0, rank[0], 0);
    endfunction

    // Mostly well-formed cells with ranks drawn close together so that ties
    // and near misses are common; the rest raw words.
    function automatic cell_t random_cell();
        int rank;
        case ($urandom_range(9))
            0, 1: return cell_t'($urandom);
            2:    return wall($urandom_range(255));
            default:
            begin
                rank = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
                return cell_word(rank, 1'b1, 1'($urandom_range(1)), $urandom_range(63));
            end
        endcase
    endfunction

    // Offer one item, idling first at the phase's rate, and hold it until the
    // core takes it. Exactly one assignment to src_valid per edge.
    task automatic send_block(input src_item_t blk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            src_item  <= src_item_t'({$urandom, $urandom, $urandom, $urandom});
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= blk;
        do
            @(posedge clk);
        while (src_stall);
    endtask

    task automatic send_cells(input cell_t c0, input cell_t c1, input cell_t c2, input cell_t c3,
                              input cell_t c4, input cell_t c5, input cell_t c6, input cell_t c7);
        src_item_t blk;
        blk.cell_0 = c0;
        blk.cell_1 = c1;
        blk.cell_2 = c2;
        blk.cell_3 = c3;
        blk.cell_4 = c4;
        blk.cell_5 = c5;
        blk.cell_6 = c6;
        blk.cell_7 = c7;
        send_block(blk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_cells(random_cell(), random_cell(), random_cell(), random_cell(),
                       random_cell(), random_cell(), random_cell(), random_cell());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks, back to back. Cell order: lower x0z0, lower x1z0,
        // upper x0z0, upper x1z0, then the same four at z1.
        send_cells('0, '0, '0, '0, '0, '0, '0, '0);
        send_cells('1, '1, '1, '1, '1, '1, '1, '1);
        // Out-of-grid cells never move, heavy over light or not.
        send_cells(wall(0), wall(1), wall(255), wall(254),
                   wall(0), wall(3), wall(255), wall(200));
        // Heavier upper cell sinks in every column.
        send_cells(solid(10), solid(11), solid(200), solid(201),
                   solid(12), solid(13), solid(202), solid(203));
        // Equal ranks: nothing swaps.
        send_cells(solid(50), solid(50), solid(50), solid(50),
                   liquid(50), liquid(50), liquid(50), liquid(50));
        // Diagonal down across x.
        send_cells(wall(0), solid(1), solid(200), wall(0),
                   wall(0), wall(0), wall(0), wall(0));
        // Diagonal down across z.
        send_cells(wall(0), wall(0), solid(200), wall(0),
                   solid(1), wall(0), wall(0), wall(0));
        // Liquid beside a lighter upper cell with a heavier cell below it.
        send_cells(wall(0), solid(150), liquid(100), solid(20),
                   solid(150), wall(0), solid(30), wall(0));
        // Liquid over lighter ground on all sides.
        send_cells(wall(9), solid(5), liquid(100), solid(20),
                   solid(5), solid(5), solid(10), solid(20));
        // Immovable heavy over movable light, and movable heavy over immovable.
        send_cells(solid(1), wall(0), wall(255), solid(255),
                   solid(1), wall(0), wall(255), solid(255));
        // Rank extremes one apart.
        send_cells(solid(254), solid(0), solid(255), solid(1),
                   liquid(0), liquid(254), liquid(1), liquid(255));
        // A cell moved down by one visit can be displaced again by the next.
        send_cells(wall(0), solid(100), solid(200), solid(150),
                   wall(0), solid(10), solid(120), solid(90));
        // Material ids pass through untouched.
        send_cells(cell_word(3, 1'b1, 1'b0, 63), cell_word(3, 1'b1, 1'b1, 0),
                   cell_word(9, 1'b1, 1'b0, 0), cell_word(9, 1'b1, 1'b1, 63),
                   cell_word(3, 1'b1, 1'b1, 21), cell_word(3, 1'b1, 1'b0, 42),
                   cell_word(9, 1'b1, 1'b1, 42), cell_word(9, 1'b1, 1'b0, 21));
        // Mixed liquids and solids in every column.
        send_cells(liquid(4), solid(2), solid(7), liquid(6),
                   solid(1), liquid(3), liquid(8), solid(5));
        send_cells(16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF,
                   16'hF0F0, 16'h0F0F, 16'hC3C3, 16'h3C3C);

        // Flat out, with one long output hold-off to fill the pipeline.
        hold_req = 1'b1;
        send_random(440);
        // Sparse sender.
        src_idle_pct = 69;
        send_random(430);
        // Heavy back-pressure.
        src_idle_pct  = 0;
        dst_stall_pct = 69;
        send_random(430);
        // Both sides idle now and then.
        src_idle_pct  = 23;
        dst_stall_pct = 23;
        send_random(430);

        // Drop valid, let the pipeline drain, then wait out its latency.
        src_valid     <= 1'b0;
        dst_stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("settled %0d blocks over four idling mixes and a %0d-cycle output hold-off;",
                 blocks_seen, HOLDOFF_CYCLES);
        $display("%0d results moved at least one cell, %0d mismatches", moved_results, errors);
        if (errors == 0)
            $display("margolus_block_density_settle_core test passed");
        else
            $display("margolus_block_density_settle_core test failed");
        $finish;
    end

endmodule

// File: margolus_block_density_settle_core.f
hdl/mbds_pkg.sv
hdl/margolus_block_density_settle_core.sv
tb/sv/mbds_settle_checker.sv
tb/sv/tb_margolus_block_density_settle_core.sv
